[design/pwm_audio_playout_with_volume_unit_defines.svh]
// Assertion macros used by the checker of the PWM audio playout unit.
`ifndef PWM_AUDIO_PLAYOUT_WITH_VOLUME_UNIT_DEFINES_SVH
`define PWM_AUDIO_PLAYOUT_WITH_VOLUME_UNIT_DEFINES_SVH

// Concurrent assertion on clk, switched off while rst_n is low.
`define PWMAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that is also checked while reset is applied.
`define PWMAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pwmap_pkg.sv]
// Shared types and constants of the PWM audio playout unit.
package pwmap_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_VOLUME = 1'b0;
  localparam logic CFG_MUTE   = 1'b1;

  localparam logic [16:0] VOLUME_RESET = 17'd50;
  localparam logic [9:0]  MID_SCALE    = 10'd512;
  localparam logic [9:0]  OUT_MIN      = 10'd50;
  localparam logic [9:0]  OUT_MAX      = 10'd975;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [9:0] pwm_compare;
    logic       frame_request;
    logic       playing;
    logic       push_dropped;
  } out_item_t;

  // Work handed from the front end to the scaling back end.
  typedef struct packed {
    logic               take;
    logic signed [15:0] raw;
    logic               frame_request;
    logic               playing;
    logic               push_dropped;
  } job_t;

endpackage

[design/pwm_audio_playout_with_volume_unit.sv]
// PWM audio playout unit with volume scaling: top level.
//
// Every accepted item gives exactly one result item. A push stores a signed
// 16-bit sample in a ring buffer of three frames (3 * FRAME_SAMPLES entries);
// a start item enables playback; a tick while playing takes the oldest sample,
// multiplies it by the volume factor, adds mid-scale 512 to the upper half of
// the 32-bit product and clamps the result to 50..975, which becomes the held
// PWM compare value. Mute or a zero factor gives 512. A tick that finds the
// buffer empty stops playback and keeps the held value. A push into a full
// buffer is discarded and flagged in push_dropped. frame_request is high while
// the buffer holds fewer than half a frame of samples. The unit takes one item
// every clock cycle unless in_stall is high (job queue full while the front
// register holds a job); the front end updates the buffer pointers and fill
// level in the cycle of acceptance. A result passes through the front
// register, job queue, multiplier register and result register. The sample
// store is a single-port-write, single-port-read memory whose contents are
// undefined after reset; only written entries are ever read, so no clearing
// pass runs. Configuration writes are always taken (cfg_ready is tied high)
// and must only be issued while the unit is idle.
module pwm_audio_playout_with_volume_unit #(
  parameter int FRAME_SAMPLES = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  pwmap_pkg::in_item_t  in_item,
  output logic                 in_stall,
  output logic                 out_valid,
  output pwmap_pkg::out_item_t out_item,
  input  logic                 out_stall,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [16:0]          cfg_data
);

  logic [16:0]     volume_r;
  logic            mute_r;
  logic            fe_valid, q_full, q_valid, q_pop;
  pwmap_pkg::job_t fe_job, q_job;

  // Configuration registers: volume factor and mute.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= pwmap_pkg::VOLUME_RESET;
      mute_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwmap_pkg::CFG_VOLUME: volume_r <= cfg_data;
        pwmap_pkg::CFG_MUTE:   mute_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The front end owns the buffer; each accepted item leaves it as one job.
  pwmap_front #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .job_valid(fe_valid),
    .job      (fe_job),
    .job_full (q_full)
  );

  // The queue lets the front end carry on while the result side is stalled.
  pwmap_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_valid),
    .push_job (fe_job),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop_job  (q_job),
    .pop      (q_pop)
  );

  // The back end scales played samples and keeps the held compare value.
  pwmap_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(q_valid),
    .job      (q_job),
    .job_pop  (q_pop),
    .volume   (volume_r),
    .mute     (mute_r),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

endmodule

[design/pwmap_front.sv]
// Front end: accepts items, keeps the ring buffer and its bookkeeping, issues jobs.
module pwmap_front #(
  parameter int FRAME_SAMPLES = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pwmap_pkg::in_item_t in_item,
  output logic              in_stall,
  output logic              job_valid,
  output pwmap_pkg::job_t   job,
  input  logic              job_full
);

  localparam int DEPTH  = 3 * FRAME_SAMPLES;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_data_r;

  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              play_r, play_nxt;
  logic              accept;
  logic              wr_en, rd_en, dropped;
  logic              s1_valid_r;
  logic              s1_take_r, s1_req_r, s1_play_r, s1_drop_r;

  assign in_stall = s1_valid_r && job_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    fill_nxt   = fill_r;
    play_nxt   = play_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    dropped    = 1'b0;
    if (accept) begin
      case (in_item.operation)
        pwmap_pkg::OP_PUSH: begin
          if (fill_r == FILL_W'(DEPTH)) begin
            dropped = 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_idx_nxt = (wr_idx_r == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
          end
        end
        pwmap_pkg::OP_TICK: begin
          if (play_r) begin
            if (fill_r != '0) begin
              rd_en      = 1'b1;
              rd_idx_nxt = (rd_idx_r == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
              fill_nxt   = fill_r - 1'b1;
            end else begin
              play_nxt = 1'b0;
            end
          end
        end
        pwmap_pkg::OP_START: begin
          play_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx_r] <= in_item.sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      fill_r     <= '0;
      play_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      fill_r   <= fill_nxt;
      play_r   <= play_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (!job_full) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_take_r <= rd_en;
      s1_req_r  <= ({fill_nxt, 1'b0} < (FILL_W + 1)'(FRAME_SAMPLES));
      s1_play_r <= play_nxt;
      s1_drop_r <= dropped;
    end
  end

  assign job_valid         = s1_valid_r;
  assign job.take          = s1_take_r;
  assign job.raw           = rd_data_r;
  assign job.frame_request = s1_req_r;
  assign job.playing       = s1_play_r;
  assign job.push_dropped  = s1_drop_r;

endmodule

[design/pwmap_queue.sv]
// Short job queue between the front end and the back end.
module pwmap_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pwmap_pkg::job_t push_job,
  output logic            full,
  output logic            pop_valid,
  output pwmap_pkg::job_t pop_job,
  input  logic            pop
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  pwmap_pkg::job_t     slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[design/pwmap_back.sv]
// Back end: volume multiply, offset and clamp, held value and result register.
module pwmap_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  pwmap_pkg::job_t      job,
  output logic                 job_pop,
  input  logic [16:0]          volume,
  input  logic                 mute,
  output logic                 out_valid,
  output pwmap_pkg::out_item_t out_item,
  input  logic                 out_stall
);

  logic signed [33:0] prod;
  logic               m_valid_r;
  pwmap_pkg::job_t    m_job_r;
  logic [15:0]        m_hi_r;
  logic               o_free, m_free, m_adv;
  logic [15:0]        offs;
  logic [9:0]         clamped;
  logic [9:0]         held_r, held_nxt;
  logic               out_valid_r;
  pwmap_pkg::out_item_t out_item_r;

  assign prod    = job.raw * $signed({1'b0, volume});
  assign o_free  = !out_valid_r || !out_stall;
  assign m_adv   = m_valid_r && o_free;
  assign m_free  = !m_valid_r || o_free;
  assign job_pop = job_valid && m_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_free) begin
      m_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      m_job_r <= job;
      m_hi_r  <= prod[31:16];
    end
  end

  // Offset wraps in 16 bits, then a signed clamp.
  always_comb begin
    offs = m_hi_r + 16'(pwmap_pkg::MID_SCALE);
    if ($signed(offs) < $signed(16'(pwmap_pkg::OUT_MIN))) begin
      clamped = pwmap_pkg::OUT_MIN;
    end else if ($signed(offs) > $signed(16'(pwmap_pkg::OUT_MAX))) begin
      clamped = pwmap_pkg::OUT_MAX;
    end else begin
      clamped = offs[9:0];
    end
    if (!m_job_r.take) begin
      held_nxt = held_r;
    end else if (mute || volume == '0) begin
      held_nxt = pwmap_pkg::MID_SCALE;
    end else begin
      held_nxt = clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= pwmap_pkg::MID_SCALE;
      out_valid_r <= 1'b0;
    end else if (m_adv) begin
      held_r      <= held_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      out_item_r.pwm_compare   <= held_nxt;
      out_item_r.frame_request <= m_job_r.frame_request;
      out_item_r.playing       <= m_job_r.playing;
      out_item_r.push_dropped  <= m_job_r.push_dropped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/pwmap_checker.sv]
// Port-level checker for the PWM audio playout unit, with its bind statement.
`include "pwm_audio_playout_with_volume_unit_defines.svh"

module pwmap_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input pwmap_pkg::out_item_t out_item,
  input logic                 out_stall
);

  `PWMAP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result item changed while stalled")
  `PWMAP_ASSERT(a_compare_range, out_valid |-> out_item.pwm_compare == pwmap_pkg::MID_SCALE || (out_item.pwm_compare >= pwmap_pkg::OUT_MIN && out_item.pwm_compare <= pwmap_pkg::OUT_MAX), "compare value outside clamp range")
  `PWMAP_ASSERT(a_drop_full, out_valid && out_item.push_dropped |-> !out_item.frame_request, "dropped push reported with frame request")
  `PWMAP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result item shown straight after reset")

endmodule

bind pwm_audio_playout_with_volume_unit pwmap_checker u_pwmap_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_item (out_item),
  .out_stall(out_stall)
);

[tb/tb.sv]
// Self-checking testbench for the PWM audio playout unit with volume scaling.
`timescale 1ns / 100ps

module tb;
  import pwmap_pkg::*;

  // The block's geometry and the timing figures that the checks lean on.
  localparam int FRAME_SAMPLES = 48;
  localparam int RING_DEPTH    = 3 * FRAME_SAMPLES;
  localparam int LATENCY       = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 42;

  // The one operation code that the package leaves unnamed.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  in_item_t    in_item;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  logic        out_stall;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [16:0] cfg_data;

  pwm_audio_playout_with_volume_unit #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Items waiting to be offered, and the status items that the block owes us.
  in_item_t  pending_items[$];
  out_item_t status_due[$];
  out_item_t due_st;

  // Idling percentages and the long receiver hold-off, set by the sequence.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  logic in_taken;
  int   err_count;
  int   quiet_cycles;

  // Our own copy of the playout state and of the two registers.
  logic [15:0] ring[RING_DEPTH];
  int          rd_ptr;
  int          wr_ptr;
  int          fill;
  logic        play_on;
  logic [9:0]  held_cmp;
  logic [16:0] vol_shadow;
  logic        mute_shadow;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The sample is sign-extended and multiplied in 32 bits, so large gains wrap.
  // Mid-scale is then added to the upper half in 16 bits, and that sum is read
  // as a signed number, so a big positive product can end up at the low clamp.
  function automatic logic [9:0] scaled_compare(input logic [15:0] raw);
    logic [31:0] prod;
    logic [15:0] upper;
    int          lvl;
    if (mute_shadow || vol_shadow == '0) return MID_SCALE;
    prod  = {{16{raw[15]}}, raw} * {15'd0, vol_shadow};
    upper = prod[31:16] + {6'd0, MID_SCALE};
    lvl   = $signed(upper);
    if (lvl < int'(OUT_MIN)) lvl = int'(OUT_MIN);
    else if (lvl > int'(OUT_MAX)) lvl = int'(OUT_MAX);
    return lvl[9:0];
  endfunction

  // Applies one accepted item to the state copy and returns the status that
  // the block must report for it. Every item, the unused code too, gives one.
  function automatic out_item_t next_status(input in_item_t it);
    out_item_t st;
    logic      dropped;
    dropped = 1'b0;
    case (it.operation)
      OP_PUSH: begin
        if (fill >= RING_DEPTH) begin
          dropped = 1'b1;
        end else begin
          ring[wr_ptr] = it.sample;
          wr_ptr       = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
          fill++;
        end
      end
      OP_TICK: begin
        if (play_on) begin
          if (fill > 0) begin
            held_cmp = scaled_compare(ring[rd_ptr]);
            rd_ptr   = (rd_ptr == RING_DEPTH - 1) ? 0 : rd_ptr + 1;
            fill--;
          end else begin
            // An empty buffer ends playback; the last compare value is held.
            play_on = 1'b0;
          end
        end
      end
      OP_START: play_on = 1'b1;
      default: ;
    endcase
    st.pwm_compare   = held_cmp;
    st.frame_request = (2 * fill < FRAME_SAMPLES);
    st.playing       = play_on;
    st.push_dropped  = dropped;
    return st;
  endfunction

  // Sender: a new item goes out only once the previous one has been taken, so
  // a stalled item is never altered and valid never follows the stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here when asked.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: handshakes are sampled at the rising edge. Results are checked
  // against the oldest expectation before the new item's status is queued.
  // The watchdog ends the run if no channel moves anything for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken     = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("status item arrived with no expectation waiting");
          err_count++;
        end else begin
          due_st = status_due.pop_front();
          if (out_item.pwm_compare !== due_st.pwm_compare) begin
            $error("pwm_compare: expected %0d, got %0d",
                   due_st.pwm_compare, out_item.pwm_compare);
            err_count++;
          end
          if (out_item.frame_request !== due_st.frame_request) begin
            $error("frame_request: expected %0b, got %0b",
                   due_st.frame_request, out_item.frame_request);
            err_count++;
          end
          if (out_item.playing !== due_st.playing) begin
            $error("playing: expected %0b, got %0b", due_st.playing, out_item.playing);
            err_count++;
          end
          if (out_item.push_dropped !== due_st.push_dropped) begin
            $error("push_dropped: expected %0b, got %0b",
                   due_st.push_dropped, out_item.push_dropped);
            err_count++;
          end
        end
      end
      if (in_taken) status_due.push_back(next_status(in_item));
      if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [15:0] smp);
    in_item_t it;
    it.operation = op;
    it.sample    = smp;
    pending_items.push_back(it);
  endtask

  // Full-scale values turn up often, so the clamps and the wrap get exercised.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Configuration writes are issued only while the block is idle.
  task automatic write_reg(input logic idx, input logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VOLUME) vol_shadow = val;
    else mute_shadow = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every item has gone in and every status has come back, then
  // lets the pipeline settle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || status_due.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mostly well-formed playout: a burst of pushes, a start and a run of ticks
  // that sometimes outlasts the buffer. The rest is noise in any order, the
  // unused code among it, and stray ticks. Items with the unused code are not counted.
  task automatic queue_traffic(input int budget);
    int         queued;
    int         k;
    int         m;
    logic [1:0] op;
    queued = 0;
    while (queued < budget) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          k = $urandom_range(1, 40);
          repeat (k) add_item(OP_PUSH, pick_sample());
          add_item(OP_START, 16'($urandom));
          m = $urandom_range(1, k + 8);
          repeat (m) add_item(OP_TICK, 16'($urandom));
          queued += k + m + 1;
        end
        6, 7: begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            op = 2'($urandom_range(3));
            add_item(op, 16'($urandom));
            if (op != OP_UNUSED) queued++;
          end
        end
        default: begin
          k = $urandom_range(1, 10);
          repeat (k) add_item(OP_TICK, 16'($urandom));
          queued += k;
        end
      endcase
    end
  endtask

  initial begin
    logic [16:0] vol;
    logic        mute_on;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_VOLUME;
    cfg_data      = '0;
    send_idle_pct = 15;
    recv_idle_pct = 61;
    hold_left     = 0;
    in_taken      = 1'b0;
    err_count     = 0;
    quiet_cycles  = 0;
    rd_ptr        = 0;
    wr_ptr        = 0;
    fill          = 0;
    play_on       = 1'b0;
    held_cmp      = MID_SCALE;
    vol_shadow    = VOLUME_RESET;
    mute_shadow   = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset gain: a tick with nothing playing, a start on an
    // empty buffer and the tick that stops it, the unused operation code, the
    // extreme samples, a start carrying a sample that must be ignored, and a
    // final tick that runs the buffer dry.
    add_item(OP_TICK, 16'h1234);
    add_item(OP_START, 16'hffff);
    add_item(OP_TICK, 16'h0000);
    add_item(OP_UNUSED, 16'h8001);
    add_item(OP_PUSH, 16'h7fff);
    add_item(OP_PUSH, 16'h8000);
    add_item(OP_PUSH, 16'h0000);
    add_item(OP_PUSH, 16'hffff);
    add_item(OP_PUSH, 16'h0001);
    add_item(OP_START, 16'h5a5a);
    repeat (6) add_item(OP_TICK, 16'hffff);
    wait_drained();

    // At unity in the upper half the offset sum overflows for large positive
    // samples and wraps negative, which lands on the low clamp; a moderate
    // sample reaches the high clamp instead.
    write_reg(CFG_VOLUME, 17'h10000);
    add_item(OP_PUSH, 16'd32256);
    add_item(OP_PUSH, 16'h7fff);
    add_item(OP_PUSH, 16'h8000);
    add_item(OP_PUSH, 16'd1000);
    add_item(OP_START, 16'h0000);
    repeat (4) add_item(OP_TICK, 16'h0000);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          vol     = 17'h1ffff;
          mute_on = 1'b0;
        end
        1: begin
          vol     = 17'h00000;
          mute_on = 1'b0;
        end
        2: begin
          vol     = 17'($urandom);
          mute_on = 1'b1;
        end
        3: begin
          vol     = 17'h00001;
          mute_on = 1'b0;
        end
        default: begin
          vol     = 17'($urandom);
          mute_on = 1'b0;
        end
      endcase
      write_reg(CFG_VOLUME, vol);
      write_reg(CFG_MUTE, {16'd0, mute_on});

      // Sender idles lightly first, then the receiver does, then neither.
      if (p < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 61;
      end else if (p < 5) begin
        send_idle_pct = 61;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // One phase overfills the buffer, so pushes are dropped, then plays
      // it out to empty.
      if (p == 5) begin
        repeat (RING_DEPTH + 6) add_item(OP_PUSH, pick_sample());
        add_item(OP_START, 16'($urandom));
        repeat (RING_DEPTH + 8) add_item(OP_TICK, 16'($urandom));
      end
      queue_traffic(PHASE_ITEMS);

      // The receiver holds off for a long stretch while items keep coming, so
      // the block fills up and stalls its input.
      if (p == 4) hold_left = 120;
      wait_drained();
    end

    if (err_count == 0 && status_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
